/* rtl/cmat_pkg.sv */
package cmat_pkg;

   // Default table depth
   localparam int MAX_RANGES_DEFAULT = 8;

   // Field widths
   localparam int ADDR_W   = 64;
   localparam int BYTES_W  = 32;
   localparam int STATUS_W = 3;
   localparam int HELD_W   = 4;
   localparam int ACTION_W = 2;
   localparam int CSR_IDX_W = 1;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_XLATE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_COVER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FS_BYTES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV_BYTES = 1'b1;

   // Stored form of one chunk: logical start, logical end (start + length,
   // never wraps once the entry passed its checks) and physical minus logical
   // start as a 65-bit two's complement value.
   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] lim;
      logic [ADDR_W:0]   delta;
   } range_entry_type;

   // Size limits from the register file
   typedef struct packed {
      logic [ADDR_W-1:0] filesystem_bytes;
      logic [ADDR_W-1:0] device_bytes;
   } cfg_type;

   // Range RAM strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_cmd_type;

endpackage

/* rtl/cmat_range_ram.sv */
module cmat_range_ram #(
   parameter int MAX_RANGES = cmat_pkg::MAX_RANGES_DEFAULT
) (
   input  logic                          clock,
   input  cmat_pkg::ram_cmd_type         cmd,
   input  logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] wr_addr,
   input  cmat_pkg::range_entry_type     wr_data,
   input  logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] rd_addr,
   output cmat_pkg::range_entry_type     rd_data
);
   import cmat_pkg::*;

   range_entry_type mem [MAX_RANGES];
   range_entry_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/cmat_engine.sv */
module cmat_engine #(
   parameter int MAX_RANGES = cmat_pkg::MAX_RANGES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cmat_pkg::cfg_type                     cfg,
   // request beat
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [cmat_pkg::ACTION_W-1:0]         req_action,
   input  logic [cmat_pkg::ADDR_W-1:0]           req_entry_logical,
   input  logic [cmat_pkg::ADDR_W-1:0]           req_entry_length,
   input  logic [cmat_pkg::ADDR_W-1:0]           req_entry_physical,
   input  logic [cmat_pkg::ADDR_W-1:0]           req_query_address,
   input  logic [cmat_pkg::BYTES_W-1:0]          req_query_bytes,
   // response beat
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [cmat_pkg::STATUS_W-1:0]         rsp_status,
   output logic [cmat_pkg::ADDR_W-1:0]           rsp_physical_address,
   output logic [cmat_pkg::HELD_W-1:0]           rsp_entries_held,
   // range RAM
   output cmat_pkg::ram_cmd_type                 ram_cmd,
   output logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] ram_wr_addr,
   output cmat_pkg::range_entry_type             ram_wr_data,
   output logic [((MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1)-1:0] ram_rd_addr,
   input  cmat_pkg::range_entry_type             ram_rd_data
);
   import cmat_pkg::*;

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_POST
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [ADDR_W-1:0]   ld_logical_ff, ld_logical_in;
   logic [ADDR_W-1:0]   ld_length_ff, ld_length_in;
   logic [ADDR_W-1:0]   ld_physical_ff, ld_physical_in;
   logic [ADDR_W-1:0]   q_addr_ff, q_addr_in;
   logic [ADDR_W:0]     q_end_ff, q_end_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_W-1:0]   res_phys_ff, res_phys_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_phys_ff, rsp_phys_in;
   logic [HELD_W-1:0]   rsp_held_ff, rsp_held_in;

   logic                accept;
   logic [CNT_W-1:0]    scan_next;
   logic [ADDR_W:0]     fs_end, dev_end;
   logic                fs_ok, dev_ok;
   logic                hit;
   logic [ADDR_W+1:0]   xlate_sum;

   assign accept    = req_valid && req_ready;
   assign scan_next = scan_ff + CNT_W'(1);

   // Load checks: start + length must stay inside both limits
   assign fs_end  = {1'b0, ld_logical_ff} + {1'b0, ld_length_ff};
   assign dev_end = {1'b0, ld_physical_ff} + {1'b0, ld_length_ff};
   assign fs_ok   = fs_end <= {1'b0, cfg.filesystem_bytes};
   assign dev_ok  = dev_end <= {1'b0, cfg.device_bytes};

   // Entry under scan covers [addr, addr + bytes) and its translation
   assign hit       = (q_addr_ff >= ram_rd_data.base) &&
                      (q_end_ff <= {1'b0, ram_rd_data.lim});
   assign xlate_sum = {2'b00, q_addr_ff} + {ram_rd_data.delta[ADDR_W], ram_rd_data.delta};

   assign ram_wr_addr       = count_ff[IDX_W-1:0];
   assign ram_wr_data.base  = ld_logical_ff;
   assign ram_wr_data.lim   = fs_end[ADDR_W-1:0];
   assign ram_wr_data.delta = {1'b0, ld_physical_ff} - {1'b0, ld_logical_ff};

   // Next state and datapath
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      ld_logical_in  = ld_logical_ff;
      ld_length_in   = ld_length_ff;
      ld_physical_in = ld_physical_ff;
      q_addr_in      = q_addr_ff;
      q_end_in       = q_end_ff;
      res_status_in  = res_status_ff;
      res_phys_in    = res_phys_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_phys_in    = rsp_phys_ff;
      rsp_held_in    = rsp_held_ff;
      ram_cmd.wr_en  = 1'b0;
      ram_cmd.rd_en  = 1'b0;
      ram_rd_addr    = scan_next[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            ram_rd_addr = '0;
            if (accept) begin
               ld_logical_in  = req_entry_logical;
               ld_length_in   = req_entry_length;
               ld_physical_in = req_entry_physical;
               q_addr_in      = req_query_address;
               q_end_in       = {1'b0, req_query_address} +
                                {{(ADDR_W + 1 - BYTES_W){1'b0}}, req_query_bytes};
               res_status_in  = ST_OK;
               res_phys_in    = '0;
               scan_in        = '0;
               state_in       = S_POST;
               case (req_action)
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_LOAD: begin
                     state_in = S_CHECK;
                  end
                  ACT_XLATE: begin
                     if (req_query_bytes == '0 || count_ff == '0) begin
                        res_status_in = ST_NO_COVER;
                     end else begin
                        ram_cmd.rd_en = 1'b1;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_CHECK: begin
            state_in = S_POST;
            if (ld_length_ff == '0) begin
               res_status_in = ST_INVALID;
               count_in      = '0;
            end else if (count_ff >= CNT_MAX) begin
               res_status_in = ST_FULL;
               count_in      = '0;
            end else if (!fs_ok || !dev_ok) begin
               res_status_in = ST_INVALID;
               count_in      = '0;
            end else begin
               ram_cmd.wr_en = 1'b1;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         S_SCAN: begin
            // one entry per cycle, next read issued alongside
            if (hit) begin
               state_in = S_POST;
               if (xlate_sum[ADDR_W]) begin
                  res_status_in = ST_OVERFLOW;
               end else begin
                  res_phys_in = xlate_sum[ADDR_W-1:0];
               end
            end else if (scan_next == count_ff) begin
               res_status_in = ST_NO_COVER;
               state_in      = S_POST;
            end else begin
               ram_cmd.rd_en = 1'b1;
               scan_in       = scan_next;
            end
         end
         S_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_phys_in   = res_phys_ff;
               rsp_held_in   = HELD_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ld_logical_ff  <= ld_logical_in;
      ld_length_ff   <= ld_length_in;
      ld_physical_ff <= ld_physical_in;
      q_addr_ff      <= q_addr_in;
      q_end_ff       <= q_end_in;
      res_status_ff  <= res_status_in;
      res_phys_ff    <= res_phys_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_phys_ff    <= rsp_phys_in;
      rsp_held_ff    <= rsp_held_in;
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_entries_held     = rsp_held_ff;

endmodule

/* rtl/chunk_map_address_translator.sv */
// Chunk range map: translates logical byte addresses to physical ones through
// a table of up to MAX_RANGES chunks kept in a single-port-read RAM. Each
// request beat gives exactly one response beat. A clear or unused action
// goes straight to the response state; a load passes the check state (check
// and append in the same cycle); a translate scans the entries in order up to
// the first covering one (at most the number held), one entry per cycle, a
// rate set by the RAM's one read port. A zero byte count or an empty table
// answers with no scan. The table needs no clearing after reset. The response
// sits in an output register, so a new request is taken while an earlier
// response waits. The user must write the two size registers through the csr
// port only while no request is in flight; the block does not enforce this.
module chunk_map_address_translator #(
   parameter int MAX_RANGES = cmat_pkg::MAX_RANGES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration writes
   input  logic                             csr_we,
   input  logic [cmat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cmat_pkg::ADDR_W-1:0]      csr_wdata,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [cmat_pkg::ACTION_W-1:0]    req_action,
   input  logic [cmat_pkg::ADDR_W-1:0]      req_entry_logical,
   input  logic [cmat_pkg::ADDR_W-1:0]      req_entry_length,
   input  logic [cmat_pkg::ADDR_W-1:0]      req_entry_physical,
   input  logic [cmat_pkg::ADDR_W-1:0]      req_query_address,
   input  logic [cmat_pkg::BYTES_W-1:0]     req_query_bytes,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [cmat_pkg::STATUS_W-1:0]    rsp_status,
   output logic [cmat_pkg::ADDR_W-1:0]      rsp_physical_address,
   output logic [cmat_pkg::HELD_W-1:0]      rsp_entries_held
);
   import cmat_pkg::*;

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

   logic [ADDR_W-1:0] fs_bytes_ff;
   logic [ADDR_W-1:0] dev_bytes_ff;
   cfg_type           cfg;
   ram_cmd_type       ram_cmd;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [IDX_W-1:0]  ram_rd_addr;
   range_entry_type   ram_wr_data;
   range_entry_type   ram_rd_data;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fs_bytes_ff  <= '0;
         dev_bytes_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FS_BYTES:  fs_bytes_ff  <= csr_wdata;
            CSR_DEV_BYTES: dev_bytes_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.filesystem_bytes = fs_bytes_ff;
   assign cfg.device_bytes     = dev_bytes_ff;

   cmat_engine #(
      .MAX_RANGES(MAX_RANGES)
   ) u_engine (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_entry_logical    (req_entry_logical),
      .req_entry_length     (req_entry_length),
      .req_entry_physical   (req_entry_physical),
      .req_query_address    (req_query_address),
      .req_query_bytes      (req_query_bytes),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_physical_address (rsp_physical_address),
      .rsp_entries_held     (rsp_entries_held),
      .ram_cmd              (ram_cmd),
      .ram_wr_addr          (ram_wr_addr),
      .ram_wr_data          (ram_wr_data),
      .ram_rd_addr          (ram_rd_addr),
      .ram_rd_data          (ram_rd_data)
   );

   cmat_range_ram #(
      .MAX_RANGES(MAX_RANGES)
   ) u_range_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

/* tb/tb_chunk_map_address_translator.sv */
`timescale 1ns / 100ps
module tb_chunk_map_address_translator;
   import cmat_pkg::*;

   localparam int DEPTH = MAX_RANGES_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam logic [ADDR_W-1:0] ALL_ONES = '1;
   // action code with no meaning: changes nothing
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   entry_logical;
      logic [ADDR_W-1:0]   entry_length;
      logic [ADDR_W-1:0]   entry_physical;
      logic [ADDR_W-1:0]   query_address;
      logic [BYTES_W-1:0]  query_bytes;
   } map_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   physical_address;
      logic [HELD_W-1:0]   entries_held;
   } map_answer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [ACTION_W-1:0]  req_action = '0;
   logic [ADDR_W-1:0]    req_entry_logical = '0;
   logic [ADDR_W-1:0]    req_entry_length = '0;
   logic [ADDR_W-1:0]    req_entry_physical = '0;
   logic [ADDR_W-1:0]    req_query_address = '0;
   logic [BYTES_W-1:0]   req_query_bytes = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ADDR_W-1:0]    rsp_physical_address;
   logic [HELD_W-1:0]    rsp_entries_held;

   // stimulus and scoreboard storage
   map_request_type request_backlog[$];
   map_answer_type  queued_answers[$];
   map_request_type in_flight_req;
   bit           steady_flow = 1'b0;
   int           mismatch_count = 0;
   int           quiet_cycles = 0;

   // predicted chunk table and size limits
   logic [ADDR_W-1:0] fs_limit = '0;
   logic [ADDR_W-1:0] dev_limit = '0;
   logic [ADDR_W-1:0] map_base[DEPTH];
   logic [ADDR_W-1:0] map_len[DEPTH];
   logic [ADDR_W-1:0] map_phys[DEPTH];
   int                map_count = 0;

   // ranges the generator expects to be loaded, for aiming translations
   logic [ADDR_W-1:0] plan_base[DEPTH];
   logic [ADDR_W-1:0] plan_len[DEPTH];
   int                plan_n = 0;

   chunk_map_address_translator #(.MAX_RANGES(DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_entry_logical(req_entry_logical),
      .req_entry_length(req_entry_length),
      .req_entry_physical(req_entry_physical),
      .req_query_address(req_query_address),
      .req_query_bytes(req_query_bytes),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_physical_address(rsp_physical_address),
      .rsp_entries_held(rsp_entries_held)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- helpers
   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] rand_upto(input logic [63:0] n);
      if (n == ALL_ONES) return rand64();
      return rand64() % (n + 64'd1);
   endfunction

   function automatic logic [63:0] lesser(input logic [63:0] a, b);
      return (a < b) ? a : b;
   endfunction

   // biased toward the corners of a 64-bit field
   function automatic logic [63:0] edgy64();
      case ($urandom_range(7))
         0: return 64'd0;
         1: return 64'd1;
         2: return ALL_ONES;
         3: return ALL_ONES - 64'd1;
         default: return rand64();
      endcase
   endfunction

   function automatic map_request_type make_req(input logic [ACTION_W-1:0] act,
                                                input logic [63:0] lstart, len, pstart,
                                                input logic [63:0] addr, nb);
      map_request_type q;
      q.action = act;
      q.entry_logical = lstart;
      q.entry_length = len;
      q.entry_physical = pstart;
      q.query_address = addr;
      q.query_bytes = nb[BYTES_W-1:0];
      return q;
   endfunction

   // ---------------------------------------------------------------- predictor
   function automatic bit lies_within(input logic [63:0] start, len, limit);
      if (len > limit) return 1'b0;
      return start <= limit - len;
   endfunction

   function automatic logic [STATUS_W-1:0] load_verdict(input logic [63:0] lstart, len,
                                                        input logic [63:0] pstart,
                                                        input int held);
      if (len == 64'd0) return ST_INVALID;
      if (held >= DEPTH) return ST_FULL;
      if (!lies_within(lstart, len, fs_limit) || !lies_within(pstart, len, dev_limit))
         return ST_INVALID;
      return ST_OK;
   endfunction

   // Applies one beat to the predicted table and returns the expected answer
   function automatic map_answer_type apply_map_action(input map_request_type q);
      map_answer_type a;
      logic [63:0] off;
      bit          found;
      int          k;
      a.status = ST_OK;
      a.physical_address = '0;
      case (q.action)
         ACT_CLEAR: map_count = 0;
         ACT_LOAD: begin
            a.status = load_verdict(q.entry_logical, q.entry_length, q.entry_physical,
                                    map_count);
            if (a.status != ST_OK) begin
               map_count = 0;
            end else begin
               map_base[map_count] = q.entry_logical;
               map_len[map_count] = q.entry_length;
               map_phys[map_count] = q.entry_physical;
               map_count++;
            end
         end
         ACT_XLATE: begin
            a.status = ST_NO_COVER;
            found = 1'b0;
            if (q.query_bytes != '0) begin
               for (k = 0; k < map_count && !found; k++) begin
                  if (q.query_address >= map_base[k]) begin
                     off = q.query_address - map_base[k];
                     if (off <= map_len[k] && 64'(q.query_bytes) <= map_len[k] - off) begin
                        // first covering chunk decides, overflow included
                        found = 1'b1;
                        if (map_phys[k] > ~off) begin
                           a.status = ST_OVERFLOW;
                        end else begin
                           a.status = ST_OK;
                           a.physical_address = map_phys[k] + off;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      a.entries_held = HELD_W'(map_count);
      return a;
   endfunction

   // ---------------------------------------------------------------- generation
   task automatic push_req(input map_request_type q);
      request_backlog.push_back(q);
      case (q.action)
         ACT_CLEAR: plan_n = 0;
         ACT_LOAD: begin
            if (load_verdict(q.entry_logical, q.entry_length, q.entry_physical, plan_n)
                == ST_OK) begin
               plan_base[plan_n] = q.entry_logical;
               plan_len[plan_n] = q.entry_length;
               plan_n++;
            end else begin
               plan_n = 0;
            end
         end
         default: ;
      endcase
   endtask

   // Load beat: a fitting entry, or one broken on purpose
   task automatic queue_load(input bit wellformed);
      logic [63:0] maxlen, len, lstart, pstart;
      maxlen = lesser(fs_limit, dev_limit);
      if (maxlen == 64'd0) begin
         len = rand_upto(64'hFF);
         lstart = rand64();
         pstart = rand64();
      end else begin
         len = ($urandom_range(3) == 0) ? 64'd1 + rand_upto(maxlen - 64'd1)
                                        : 64'd1 + rand_upto(lesser(maxlen - 64'd1, 64'hFFFF));
         lstart = ($urandom_range(7) == 0) ? fs_limit - len : rand_upto(fs_limit - len);
         pstart = ($urandom_range(7) == 0) ? dev_limit - len : rand_upto(dev_limit - len);
         if (!wellformed) begin
            case ($urandom_range(3))
               0: len = 64'd0;
               1: lstart = fs_limit - len + 64'd1;
               2: pstart = dev_limit - len + 64'd1;
               default: begin
                  // longer than one of the sizes
                  if (fs_limit != ALL_ONES) len = fs_limit + 64'd1;
                  else if (dev_limit != ALL_ONES) len = dev_limit + 64'd1;
                  else len = 64'd0;
               end
            endcase
         end
      end
      push_req(make_req(ACT_LOAD, lstart, len, pstart, rand64(), rand64()));
   endtask

   // Translate beat: mostly aimed at a planned chunk, edges included
   task automatic queue_translate();
      logic [63:0] base, len, off, room, addr, nb;
      int k;
      if (plan_n != 0 && $urandom_range(3) != 0) begin
         k = $urandom_range(plan_n - 1);
         base = plan_base[k];
         len = plan_len[k];
         case ($urandom_range(9))
            7: begin
               // runs one byte past the chunk end
               room = 64'd1 + rand_upto(lesser(len - 64'd1, 64'hFF));
               off = len - room;
               nb = room + 64'd1;
               addr = base + off;
            end
            8: begin
               addr = base - 64'd1;
               nb = 64'd1;
            end
            9: begin
               addr = base + len;
               nb = 64'd1;
            end
            default: begin
               off = $urandom_range(1) ? rand_upto(len - 64'd1)
                                       : rand_upto(lesser(len - 64'd1, 64'hFF));
               room = lesser(len - off, 64'hFFFF_FFFF);
               nb = $urandom_range(1) ? room
                                      : 64'd1 + rand_upto(lesser(room - 64'd1, 64'hFF));
               addr = base + off;
            end
         endcase
      end else begin
         addr = edgy64();
         nb = edgy64();
      end
      push_req(make_req(ACT_XLATE, rand64(), rand64(), rand64(), addr, nb));
   endtask

   task automatic queue_phase(input int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < 5)
            push_req(make_req(ACT_CLEAR, rand64(), rand64(), rand64(), rand64(), rand64()));
         else if (pick < 45)
            queue_load($urandom_range(4) != 0);
         else if (pick < 88)
            queue_translate();
         else
            push_req(make_req(ACTION_W'($urandom_range(3)), edgy64(), edgy64(), edgy64(),
                              edgy64(), edgy64()));
      end
   endtask

   // Corner cases, run with both sizes at their maximum
   task automatic queue_directed();
      int i;
      push_req(make_req(ACT_XLATE, 0, 0, 0, 0, 1));                 // empty table
      push_req(make_req(ACT_LOAD, 0, 0, 0, 0, 0));                  // zero length
      push_req(make_req(ACT_LOAD, 0, 64'h1000, 64'h8000_0000_0000_0000, 0, 0));
      push_req(make_req(ACT_XLATE, 0, 0, 0, 64'h10, 0));            // zero bytes
      push_req(make_req(ACT_XLATE, 0, 0, 0, 64'hFFF, 1));           // last byte
      push_req(make_req(ACT_XLATE, 0, 0, 0, 64'hFFF, 2));           // crosses end
      push_req(make_req(ACT_XLATE, 0, 0, 0, 64'h1000, 1));          // just past end
      push_req(make_req(ACT_XLATE, 0, 0, 0, 0, 64'hFFFF_FFFF));     // widest query
      // chunk ending at the top of both spaces
      push_req(make_req(ACT_LOAD, 64'hFFFF_FFFF_FFFF_EFFF, 64'h1000,
                        64'hFFFF_FFFF_FFFF_EFFF, 0, 0));
      push_req(make_req(ACT_XLATE, 0, 0, 0, ALL_ONES - 64'd1, 1));
      push_req(make_req(ACT_XLATE, 0, 0, 0, ALL_ONES, 1));
      // one byte too high: rejected, table emptied
      push_req(make_req(ACT_LOAD, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 0, 0, 0));
      push_req(make_req(ACT_XLATE, 0, 0, 0, 64'hFFF, 1));
      push_req(make_req(ACT_SPARE, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
      // all of the address space but its last byte in one chunk
      push_req(make_req(ACT_LOAD, 0, ALL_ONES, 0, 0, 0));
      push_req(make_req(ACT_XLATE, 0, 0, 0, ALL_ONES - 64'd1, 1));
      // fill the table, then overfill it
      for (i = 1; i < DEPTH; i++)
         push_req(make_req(ACT_LOAD, 64'(i) << 8, 64'h100, ALL_ONES - (64'(i) << 12), 0, 0));
      push_req(make_req(ACT_LOAD, 64'h5000, 64'h10, 64'h5000, 0, 0));
      push_req(make_req(ACT_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
   endtask

   // ---------------------------------------------------------------- sequencing
   task automatic settle_idle();
      while (request_backlog.size() != 0 || req_valid || queued_answers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_sizes(input logic [63:0] fs, dev);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_FS_BYTES;
      csr_wdata <= fs;
      @(posedge clock);
      csr_index <= CSR_DEV_BYTES;
      csr_wdata <= dev;
      @(posedge clock);
      csr_we <= 1'b0;
      fs_limit = fs;
      dev_limit = dev;
   endtask

   task automatic run_phase(input logic [63:0] fs, dev, input bit steady, input int n);
      settle_idle();
      program_sizes(fs, dev);
      steady_flow = steady;
      queue_phase(n);
   endtask

   task automatic flag_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      program_sizes(ALL_ONES, ALL_ONES);
      queue_directed();
      run_phase(ALL_ONES, ALL_ONES, 1'b1, 95);
      run_phase(64'h0000_0100_0000_0000, 64'h0000_0010_0000_0000, 1'b0, 95);
      run_phase(rand64(), rand64(), 1'b0, 95);
      run_phase(64'd0, 64'd0, 1'b0, 40);
      run_phase(ALL_ONES, 64'h0010_0000, 1'b0, 95);
      run_phase(64'h1000, ALL_ONES, 1'b0, 95);
      run_phase(64'd1, 64'd1, 1'b0, 40);
      run_phase(ALL_ONES, ALL_ONES, 1'b0, 95);
      settle_idle();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      bit took;
      bit hold_off;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && req_ready;
         if (took) queued_answers.push_back(apply_map_action(in_flight_req));
         if (!req_valid || took) begin
            hold_off = !steady_flow && ($urandom_range(99) < 26);
            if (request_backlog.size() != 0 && !hold_off) begin
               in_flight_req = request_backlog.pop_front();
               req_action <= in_flight_req.action;
               req_entry_logical <= in_flight_req.entry_logical;
               req_entry_length <= in_flight_req.entry_length;
               req_entry_physical <= in_flight_req.entry_physical;
               req_query_address <= in_flight_req.query_address;
               req_query_bytes <= in_flight_req.query_bytes;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      map_answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (queued_answers.size() == 0) begin
               flag_mismatch($sformatf("response beat with none expected, status %0d",
                                       rsp_status));
            end else begin
               want = queued_answers.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status %0d, expected %0d",
                                          rsp_status, want.status));
               if (rsp_physical_address !== want.physical_address)
                  flag_mismatch($sformatf("physical_address %h, expected %h",
                                          rsp_physical_address, want.physical_address));
               if (rsp_entries_held !== want.entries_held)
                  flag_mismatch($sformatf("entries_held %0d, expected %0d",
                                          rsp_entries_held, want.entries_held));
            end
         end
         rsp_ready <= steady_flow || ($urandom_range(99) >= 26);
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("ERROR at %0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
